/* hdl/wsp_pkg.sv */
// Package for the world-to-screen projection block: item types, widths, opcodes.
// Used by wsp_clip, wsp_div and world_to_screen_projection_top.
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int COORD_BITS  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int COORD_SHIFT = 32 - COORD_BITS;

	localparam int MAT_DEPTH = 16;
	localparam int TERM_W    = 40;
	localparam int CONST_W   = 24;
	localparam int CLIP_W    = 42;
	localparam int NUM_W     = 43;
	localparam int DEN_W     = 42;
	localparam int DIM_W     = 15;
	localparam int SCALE_W   = 22;
	localparam int DPROD_W   = 65;
	localparam int QUO_W     = 32;
	localparam int DIV_LAT   = 34;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 15'd1920;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 15'd1080;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_PROJECT = 1'b1
	} op_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t                opcode;
		logic [3:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic               in_front;
		logic               on_screen;
	} out_item_t;

	typedef struct packed {
		logic                     valid;
		logic signed [CLIP_W-1:0] cx;
		logic signed [CLIP_W-1:0] cy;
		logic signed [CLIP_W-1:0] cz;
		logic signed [CLIP_W-1:0] cw;
	} clip_t;

endpackage

`default_nettype wire

/* hdl/wsp_clip.sv */
// Matrix store and clip-space transform: products in stage 1, row sums in stage 2.
// Depends on wsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsp_clip (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             acc,
	input  wire wsp_pkg::in_item_t item,
	output wsp_pkg::clip_t        clip
);

	logic signed [31:0] mat_q [wsp_pkg::MAT_DEPTH];
	logic signed [31:0] crd [3];
	logic signed [63:0] full [12];
	logic signed [wsp_pkg::TERM_W-1:0]  term [12];
	logic signed [wsp_pkg::CONST_W-1:0] cterm [4];

	logic                               valid_s1;
	logic signed [wsp_pkg::TERM_W-1:0]  term_s1 [12];
	logic signed [wsp_pkg::CONST_W-1:0] cterm_s1 [4];

	logic                               valid_s2;
	logic signed [wsp_pkg::CLIP_W-1:0]  sum [4];
	logic signed [wsp_pkg::CLIP_W-1:0]  sum_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsp_pkg::MAT_DEPTH; i++) begin
				mat_q[i] <= '0;
			end
		end else if (acc && item.opcode == wsp_pkg::OP_LOAD) begin
			mat_q[item.entry_index] <= item.entry_value;
		end
	end

	always_comb begin
		crd[0] = $signed(item.world_x << wsp_pkg::COORD_SHIFT) >>> wsp_pkg::COORD_SHIFT;
		crd[1] = $signed(item.world_y << wsp_pkg::COORD_SHIFT) >>> wsp_pkg::COORD_SHIFT;
		crd[2] = $signed(item.world_z << wsp_pkg::COORD_SHIFT) >>> wsp_pkg::COORD_SHIFT;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 4; r++) begin
				full[c*4+r] = mat_q[c*4+r] * crd[c];
				term[c*4+r] = full[c*4+r][63:24];
			end
		end
		for (int r = 0; r < 4; r++) begin
			cterm[r] = mat_q[12+r][31:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc && item.opcode == wsp_pkg::OP_PROJECT;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s1  <= term;
			cterm_s1 <= cterm;
			sum_s2   <= sum;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = wsp_pkg::CLIP_W'(term_s1[r]) + wsp_pkg::CLIP_W'(term_s1[4+r])
				+ wsp_pkg::CLIP_W'(term_s1[8+r]) + wsp_pkg::CLIP_W'(cterm_s1[r]);
		end
	end

	assign clip.valid = valid_s2;
	assign clip.cx    = sum_s2[0];
	assign clip.cy    = sum_s2[1];
	assign clip.cz    = sum_s2[2];
	assign clip.cw    = sum_s2[3];

endmodule

`default_nettype wire

/* hdl/wsp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, floor rounding and saturation.
// Depends on wsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsp_div (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [wsp_pkg::DPROD_W-1:0] prod,
	input  wire logic [wsp_pkg::DEN_W-1:0]   den,
	input  wire logic                        neg,
	output logic signed [wsp_pkg::QUO_W-1:0] quo
);

	localparam int NST = wsp_pkg::QUO_W;
	localparam int TW  = wsp_pkg::DEN_W + wsp_pkg::QUO_W;

	logic [wsp_pkg::DPROD_W-1:0] rem_s [NST+1];
	logic [wsp_pkg::DEN_W-1:0]   den_s [NST+1];
	logic [wsp_pkg::QUO_W-1:0]   q_s   [NST+1];
	logic                        neg_s [NST+1];
	logic                        ovf_s [NST+1];
	logic signed [wsp_pkg::QUO_W-1:0] res_s;

	logic [wsp_pkg::QUO_W:0] t;
	logic [wsp_pkg::QUO_W:0] neg_t;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= prod;
			den_s[0] <= den;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= wsp_pkg::DEN_W'(prod[wsp_pkg::DPROD_W-1:wsp_pkg::QUO_W]) >= den;
		end
	end

	for (genvar j = 0; j < NST; j++) begin : g_step
		localparam int B = NST - 1 - j;
		logic [TW-1:0]             trial;
		logic                      take;
		logic [wsp_pkg::QUO_W-1:0] q_next;

		always_comb begin
			trial     = TW'(den_s[j]) << B;
			take      = TW'(rem_s[j]) >= trial;
			q_next    = q_s[j];
			q_next[B] = take;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? rem_s[j] - trial[wsp_pkg::DPROD_W-1:0] : rem_s[j];
				den_s[j+1] <= den_s[j];
				q_s[j+1]   <= q_next;
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	always_comb begin
		t     = {1'b0, q_s[NST]} + (wsp_pkg::QUO_W+1)'(rem_s[NST] != '0);
		neg_t = '0 - t;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NST]) begin
				if (ovf_s[NST] || t > (wsp_pkg::QUO_W+1)'(33'h0_8000_0000)) begin
					res_s <= 32'sh8000_0000;
				end else begin
					res_s <= neg_t[wsp_pkg::QUO_W-1:0];
				end
			end else begin
				if (ovf_s[NST] || q_s[NST][wsp_pkg::QUO_W-1]) begin
					res_s <= 32'sh7FFF_FFFF;
				end else begin
					res_s <= q_s[NST];
				end
			end
		end
	end

	assign quo = res_s;

endmodule

`default_nettype wire

/* hdl/world_to_screen_projection_top.sv */
// World-to-screen projection: perspective transform, divide by w, viewport map.
// Instantiates wsp_clip and two wsp_div lanes; depends on wsp_pkg.
//
// Input channel item/item_valid/item_stall carries load items (one matrix entry,
// no result) and project items (one world point, one result). Results leave on
// result/result_valid/result_stall. cfg_we/cfg_index/cfg_data set the display
// width and height; write them only while no item is in flight.
// Throughput: one item per cycle while no waiting result is stalled. A project
// item's result is registered at the output after registered stages of matrix
// products, row sums, numerator and scale multiply and the bit-per-stage divider,
// then the bound test. A load item writes the matrix at its acceptance edge and
// affects every project item accepted after it.
// Reset clears the matrix, empties the pipeline and sets the display to
// 1920 x 1080. When the receiver stalls a waiting result, the whole pipeline
// holds and item_stall rises; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module world_to_screen_projection_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire wsp_pkg::in_item_t        item,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output wsp_pkg::out_item_t            result,
	input  wire logic                     cfg_we,
	input  wire logic [0:0]               cfg_index,
	input  wire logic [wsp_pkg::DIM_W-1:0] cfg_data
);

	typedef struct packed {
		logic valid;
		logic front;
		logic wz;
	} side_t;

	logic [wsp_pkg::DIM_W-1:0] width_q;
	logic [wsp_pkg::DIM_W-1:0] height_q;

	logic en;
	logic acc;
	wsp_pkg::clip_t clip;

	logic signed [wsp_pkg::NUM_W-1:0] nx;
	logic signed [wsp_pkg::NUM_W-1:0] ny;

	side_t                     side_s3;
	logic [wsp_pkg::NUM_W-1:0] magx_s3;
	logic [wsp_pkg::NUM_W-1:0] magy_s3;
	logic [wsp_pkg::DEN_W-1:0] den_s3;
	logic                      negx_s3;
	logic                      negy_s3;

	side_t                       side_s4;
	logic [wsp_pkg::DPROD_W-1:0] prodx_s4;
	logic [wsp_pkg::DPROD_W-1:0] prody_s4;
	logic [wsp_pkg::DEN_W-1:0]   den_s4;
	logic                        negx_s4;
	logic                        negy_s4;

	logic [wsp_pkg::SCALE_W-1:0] kx;
	logic [wsp_pkg::SCALE_W-1:0] ky;

	side_t side_s [wsp_pkg::DIV_LAT];
	logic signed [wsp_pkg::QUO_W-1:0] sx;
	logic signed [wsp_pkg::QUO_W-1:0] sy;
	logic on;

	logic                 result_valid_q;
	wsp_pkg::out_item_t   result_q;

	assign en         = !(result_valid_q && result_stall);
	assign item_stall = !en;
	assign acc        = item_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= wsp_pkg::WIDTH_RESET;
			height_q <= wsp_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (wsp_pkg::cfg_reg_t'(cfg_index))
				wsp_pkg::REG_WIDTH:  width_q  <= cfg_data;
				wsp_pkg::REG_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	wsp_clip u_clip (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.acc    (acc),
		.item   (item),
		.clip   (clip)
	);

	always_comb begin
		nx = wsp_pkg::NUM_W'(clip.cx) + wsp_pkg::NUM_W'(clip.cw);
		ny = wsp_pkg::NUM_W'(clip.cw) - wsp_pkg::NUM_W'(clip.cy);
		kx = {width_q, 7'b0};
		ky = {height_q, 7'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
			side_s4 <= '0;
			for (int i = 0; i < wsp_pkg::DIV_LAT; i++) begin
				side_s[i] <= '0;
			end
			result_valid_q <= 1'b0;
		end else if (en) begin
			side_s3.valid <= clip.valid;
			side_s3.front <= !clip.cz[wsp_pkg::CLIP_W-1];
			side_s3.wz    <= clip.cw == '0;
			side_s4       <= side_s3;
			side_s[0]     <= side_s4;
			for (int i = 1; i < wsp_pkg::DIV_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
			result_valid_q <= side_s[wsp_pkg::DIV_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s3  <= nx[wsp_pkg::NUM_W-1] ? wsp_pkg::NUM_W'(-nx) : wsp_pkg::NUM_W'(nx);
			magy_s3  <= ny[wsp_pkg::NUM_W-1] ? wsp_pkg::NUM_W'(-ny) : wsp_pkg::NUM_W'(ny);
			den_s3   <= clip.cw[wsp_pkg::CLIP_W-1] ? wsp_pkg::DEN_W'(-clip.cw)
				: wsp_pkg::DEN_W'(clip.cw);
			negx_s3  <= nx[wsp_pkg::NUM_W-1] != clip.cw[wsp_pkg::CLIP_W-1];
			negy_s3  <= ny[wsp_pkg::NUM_W-1] != clip.cw[wsp_pkg::CLIP_W-1];
			prodx_s4 <= wsp_pkg::DPROD_W'(magx_s3) * wsp_pkg::DPROD_W'(kx);
			prody_s4 <= wsp_pkg::DPROD_W'(magy_s3) * wsp_pkg::DPROD_W'(ky);
			den_s4   <= den_s3;
			negx_s4  <= negx_s3;
			negy_s4  <= negy_s3;
		end
	end

	wsp_div u_div_x (
		.clk  (clk),
		.en   (en),
		.prod (prodx_s4),
		.den  (den_s4),
		.neg  (negx_s4),
		.quo  (sx)
	);

	wsp_div u_div_y (
		.clk  (clk),
		.en   (en),
		.prod (prody_s4),
		.den  (den_s4),
		.neg  (negy_s4),
		.quo  (sy)
	);

	always_comb begin
		on = side_s[wsp_pkg::DIV_LAT-1].front && !side_s[wsp_pkg::DIV_LAT-1].wz
			&& !sx[wsp_pkg::QUO_W-1] && !sy[wsp_pkg::QUO_W-1]
			&& sx <= $signed({9'b0, width_q, 8'b0})
			&& sy <= $signed({9'b0, height_q, 8'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[wsp_pkg::DIV_LAT-1].front && !side_s[wsp_pkg::DIV_LAT-1].wz) begin
				result_q.screen_x <= sx;
				result_q.screen_y <= sy;
			end else begin
				result_q.screen_x <= '0;
				result_q.screen_y <= '0;
			end
			result_q.in_front  <= side_s[wsp_pkg::DIV_LAT-1].front;
			result_q.on_screen <= on;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
